FILE: src/sct_pkg.sv
package sct_pkg;

  // Table geometry
  localparam int POSITIONS  = 4096;
  localparam int CATEGORIES = 8;
  localparam int COUNT_BITS = 16;

  localparam int POS_BITS = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
  localparam int CAT_BITS = (CATEGORIES > 1) ? $clog2(CATEGORIES) : 1;
  // wide enough for position + run_length and for any row index
  localparam int ADDR_W   = ((POS_BITS > 13) ? POS_BITS : 13) + 1;
  // counter + amount without overflow
  localparam int SUM_BITS = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;
  localparam int ROW_BITS = CATEGORIES * COUNT_BITS;

  localparam logic [63:0] COUNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;
  localparam logic [ADDR_W-1:0] LAST_ROW = ADDR_W'(POSITIONS - 1);

  // Register indexes
  localparam logic [0:0] REG_MAX_COVERAGE  = 1'b0;
  localparam logic [0:0] REG_LENGTH_IN_USE = 1'b1;

  typedef enum logic [2:0] {
    OP_POINT_ADD = 3'd0,
    OP_RANGE_ADD = 3'd1,
    OP_SET       = 3'd2,
    OP_GET       = 3'd3,
    OP_HIGH_TEST = 3'd4,
    OP_CLEAR     = 3'd5
  } opcode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_READ,
    ST_MODIFY,
    ST_FINISH
  } state_t;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [CATEGORIES-1:0][COUNT_BITS-1:0] row_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [11:0] position;
    logic [2:0]  category;
    logic [12:0] run_length;
    logic [15:0] amount;
  } cmd_t;

  typedef struct packed {
    logic [15:0] coverage_value;
    logic        high_flag;
  } res_t;

  // Compare results of the shared unit
  typedef struct packed {
    logic lt;      // counter + amount <  cap
    logic le;      // counter + amount <= cap
    logic ge;      // counter >= cap
    logic amt_le;  // amount <= cap
  } cmp_t;

endpackage

FILE: src/sct_ram.sv
module sct_ram #(
  parameter int ADDR_BITS = 12,
  parameter int DATA_BITS = 128,
  parameter int DEPTH     = 4096
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/sct_unit.sv
module sct_unit import sct_pkg::*; (
  input  row_t                row,
  input  logic [2:0]          category,
  input  logic [15:0]         amount,
  input  logic [SUM_BITS-1:0] cap,
  input  logic                use_amt,
  output count_t              lane,
  output row_t                new_row,
  output cmp_t                cmp
);

  logic [SUM_BITS-1:0] lane_ext;
  logic [SUM_BITS-1:0] amt_ext;
  logic [SUM_BITS-1:0] sum;
  logic [CAT_BITS-1:0] sel;

  // Lane select, one add, compares against the cap
  always_comb begin
    sel      = CAT_BITS'(category);
    lane     = row[sel];
    lane_ext = SUM_BITS'(lane);
    amt_ext  = SUM_BITS'(amount);
    sum      = lane_ext + amt_ext;
    cmp.lt     = sum < cap;
    cmp.le     = sum <= cap;
    cmp.ge     = lane_ext >= cap;
    cmp.amt_le = amt_ext <= cap;
    // new_row carries the sum, or the amount when use_amt is set; the caller gates the write on the cap
    new_row      = row;
    new_row[sel] = use_amt ? COUNT_BITS'(amount) : COUNT_BITS'(sum);
  end

endmodule

FILE: src/saturating_coverage_table_top.sv
// Saturating coverage table: POSITIONS x CATEGORIES counters kept as one row of all
// categories per position in a single-port-write, registered-read memory. Items are
// handled one at a time by a small sequencer around one shared add/compare unit, and
// cmd_ready is high only while the sequencer is idle. Each row access is a read step
// followed by a modify/write step; a range add repeats the pair for each position
// covered, a high test for each of its three rows, and an item that touches nothing
// goes from start straight to finish. Clear writes one zero row per cycle. After reset
// the same sweep runs once over all POSITIONS rows (4096 by default) before the first
// item is accepted; configuration writes are taken at any time. A waiting result does
// not hold off accepting the next item, only that item's finish step waits for the slot.
module saturating_coverage_table_top import sct_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  output logic        res_valid,
  input  logic        res_ready,
  output res_t        res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  state_t state, state_next;

  logic [15:0]         max_coverage;
  logic [12:0]         length_in_use;
  cmd_t                item;
  logic [ADDR_W-1:0]   cur;
  logic [ADDR_W-1:0]   stop;
  logic [1:0]          hstep;
  logic                flag_acc;
  logic [15:0]         hold_value;
  logic                hold_flag;
  logic                clr_reply;

  logic [12:0]         eff_len;
  logic [SUM_BITS-1:0] cap_cfg;
  logic [SUM_BITS-1:0] cap_lim;
  logic [SUM_BITS-1:0] eff_cap;
  logic [ADDR_W-1:0]   pos_a;
  logic [ADDR_W-1:0]   run_a;
  logic [ADDR_W-1:0]   len_a;
  logic [ADDR_W-1:0]   span_end;
  logic [ADDR_W-1:0]   clip_end;
  logic [ADDR_W-1:0]   cur_inc;
  logic                cat_ok;
  logic                slot_free;
  logic                write_ok;

  logic                ram_we;
  logic                ram_re;
  logic [POS_BITS-1:0] ram_addr;
  row_t                ram_wdata;
  row_t                ram_rdata;
  row_t                unit_row;
  count_t              lane;
  cmp_t                cmp;

  // Effective length, cap and addresses of the held item
  always_comb begin
    eff_len  = (32'(length_in_use) < POSITIONS) ? length_in_use : 13'(POSITIONS);
    cap_cfg  = SUM_BITS'(max_coverage);
    cap_lim  = SUM_BITS'(COUNT_MAX);
    eff_cap  = (cap_cfg < cap_lim) ? cap_cfg : cap_lim;
    pos_a    = ADDR_W'(item.position);
    run_a    = ADDR_W'(item.run_length);
    len_a    = ADDR_W'(eff_len);
    span_end = pos_a + run_a;
    clip_end = (span_end > len_a) ? len_a : span_end;
    cur_inc  = cur + ADDR_W'(1);
    cat_ok   = 32'(item.category) < CATEGORIES;
    slot_free = !res_valid || res_ready;
  end

  sct_ram #(
    .ADDR_BITS (POS_BITS),
    .DATA_BITS (ROW_BITS),
    .DEPTH     (POSITIONS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  sct_unit u_unit (
    .row      (ram_rdata),
    .category (item.category),
    .amount   (item.amount),
    .cap      (eff_cap),
    .use_amt  (item.opcode == OP_SET),
    .lane     (lane),
    .new_row  (unit_row),
    .cmp      (cmp)
  );

  // Whether the modified row goes back to memory
  always_comb begin
    case (item.opcode)
      OP_POINT_ADD: write_ok = cmp.lt;
      OP_RANGE_ADD: write_ok = cmp.le;
      OP_SET:       write_ok = cmp.amt_le;
      default:      write_ok = 1'b0;
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (cur == LAST_ROW) begin
          state_next = clr_reply ? ST_FINISH : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          state_next = ST_START;
        end
      end
      ST_START: begin
        case (item.opcode)
          OP_POINT_ADD, OP_SET, OP_GET:
            state_next = (cat_ok && pos_a < len_a) ? ST_READ : ST_FINISH;
          OP_RANGE_ADD:
            state_next = (cat_ok && pos_a < clip_end) ? ST_READ : ST_FINISH;
          OP_HIGH_TEST:
            state_next = (cat_ok && span_end < len_a) ? ST_READ : ST_FINISH;
          OP_CLEAR:
            state_next = ST_CLEAR;
          default:
            state_next = ST_FINISH;
        endcase
      end
      ST_READ: begin
        state_next = ST_MODIFY;
      end
      ST_MODIFY: begin
        if (item.opcode == OP_RANGE_ADD && cur_inc < stop) begin
          state_next = ST_READ;
        end else if (item.opcode == OP_HIGH_TEST && hstep != 2'd2) begin
          state_next = ST_READ;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake and memory controls
  always_comb begin
    cmd_ready = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_wdata = unit_row;
    ram_addr  = POS_BITS'(cur);
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
      end
      ST_IDLE:   cmd_ready = 1'b1;
      ST_READ:   ram_re = 1'b1;
      ST_MODIFY: ram_we = write_ok;
      default: begin
      end
    endcase
  end

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_coverage  <= 16'hFFFF;
      length_in_use <= 13'd4096;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAX_COVERAGE:  max_coverage  <= cfg_data;
        REG_LENGTH_IN_USE: length_in_use <= cfg_data[12:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cur       <= '0;
      clr_reply <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      // result slot: loaded from the finish step, emptied when taken
      if (state == ST_FINISH && slot_free) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          cur <= cur_inc;
          if (cur == LAST_ROW) begin
            clr_reply <= 1'b0;
          end
        end
        ST_IDLE: begin
          if (cmd_valid) begin
            item <= cmd;
          end
        end
        ST_START: begin
          hold_value <= '0;
          hold_flag  <= 1'b0;
          flag_acc   <= 1'b1;
          hstep      <= 2'd0;
          stop       <= clip_end;
          if (item.opcode == OP_CLEAR) begin
            cur       <= '0;
            clr_reply <= 1'b1;
          end else begin
            cur <= pos_a;
          end
        end
        ST_MODIFY: begin
          case (item.opcode)
            OP_GET:       hold_value <= 16'(lane);
            OP_RANGE_ADD: cur <= cur_inc;
            OP_HIGH_TEST: begin
              flag_acc <= flag_acc & cmp.ge;
              hstep    <= hstep + 2'd1;
              cur      <= (hstep == 2'd0) ? pos_a + (run_a >> 1) : span_end;
              if (hstep == 2'd2) begin
                hold_flag <= flag_acc & cmp.ge;
              end
            end
            default: begin
            end
          endcase
        end
        ST_FINISH: begin
          if (slot_free) begin
            res.coverage_value <= hold_value;
            res.high_flag      <= hold_flag;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: tb/saturating_coverage_table_top_tb.sv
module saturating_coverage_table_top_tb;
  import sct_pkg::*;

  // Opcodes the block treats as no-ops
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 50;
  localparam int PHASE_ITEMS   = 75;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cmd_valid = 1'b0;
  logic        cmd_ready;
  cmd_t        cmd = '0;
  logic        res_valid;
  logic        res_ready = 1'b0;
  res_t        res;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = REG_MAX_COVERAGE;
  logic [15:0] cfg_data = '0;

  saturating_coverage_table_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the table and its limits
  count_t      coverage_model [POSITIONS*CATEGORIES];
  logic [15:0] cap_shadow = 16'hFFFF;
  logic [12:0] length_shadow = 13'd4096;

  cmd_t pending_cmds[$];
  res_t expected_results[$];
  res_t oldest_expected;

  int cycle_count = 0;
  int error_count = 0;
  int items_accepted = 0;
  int high_hits = 0;
  int clears_seen = 0;
  int settings_used = 1;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int window_base = 0;
  logic [2:0] window_cat = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("MISMATCH @%0d: %s", cycle_count, msg);
  endtask

  function automatic int slot(input int pos, input int cat);
    return pos * CATEGORIES + cat;
  endfunction

  function automatic int active_length();
    return (int'(length_shadow) < POSITIONS) ? int'(length_shadow) : POSITIONS;
  endfunction

  // Applies one op to the shadow table and returns the result it yields
  function automatic res_t apply_table_op(input cmd_t c);
    res_t        r;
    int          len_eff;
    int          pos;
    int          last;
    int          mid;
    int          k;
    logic [16:0] sum;
    bit          cat_ok;
    r = '0;
    len_eff = active_length();
    pos = int'(c.position);
    cat_ok = int'(c.category) < CATEGORIES;
    case (c.opcode)
      OP_POINT_ADD: begin
        if (cat_ok && pos < len_eff) begin
          k = slot(pos, c.category);
          sum = 17'(coverage_model[k]) + 17'(c.amount);
          if (sum < 17'(cap_shadow))
            coverage_model[k] = sum[15:0];
        end
      end
      OP_RANGE_ADD: begin
        if (cat_ok) begin
          last = pos + int'(c.run_length);
          if (last > len_eff)
            last = len_eff;
          for (int p = pos; p < last; p++) begin
            k = slot(p, c.category);
            sum = 17'(coverage_model[k]) + 17'(c.amount);
            if (sum <= 17'(cap_shadow))
              coverage_model[k] = sum[15:0];
          end
        end
      end
      OP_SET: begin
        if (cat_ok && pos < len_eff && c.amount <= cap_shadow)
          coverage_model[slot(pos, c.category)] = c.amount;
      end
      OP_GET: begin
        if (cat_ok && pos < len_eff)
          r.coverage_value = coverage_model[slot(pos, c.category)];
      end
      OP_HIGH_TEST: begin
        last = pos + int'(c.run_length);
        mid = pos + int'(c.run_length) / 2;
        if (cat_ok && last < len_eff &&
            coverage_model[slot(pos, c.category)] >= cap_shadow &&
            coverage_model[slot(mid, c.category)] >= cap_shadow &&
            coverage_model[slot(last, c.category)] >= cap_shadow) begin
          r.high_flag = 1'b1;
          high_hits++;
        end
      end
      OP_CLEAR: begin
        foreach (coverage_model[i])
          coverage_model[i] = '0;
        clears_seen++;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic cmd_t make_cmd(input logic [2:0] op, input int pos, input int cat,
                                    input int run, input int amt);
    cmd_t c;
    c.opcode     = op;
    c.position   = 12'(pos);
    c.category   = 3'(cat);
    c.run_length = 13'(run);
    c.amount     = 16'(amt);
    return c;
  endfunction

  // Random op aimed at a small window so ops act on each other's counters
  function automatic cmd_t random_table_op();
    cmd_t c;
    int   sel;
    int   len_eff;
    int   pos;
    len_eff = active_length();
    sel = $urandom_range(0, 99);
    if (sel < 20)      c.opcode = OP_POINT_ADD;
    else if (sel < 40) c.opcode = OP_RANGE_ADD;
    else if (sel < 55) c.opcode = OP_SET;
    else if (sel < 75) c.opcode = OP_GET;
    else if (sel < 96) c.opcode = OP_HIGH_TEST;
    else if (sel < 98) c.opcode = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
    else               c.opcode = OP_CLEAR;

    sel = $urandom_range(0, 99);
    if (sel < 70)      pos = window_base + $urandom_range(0, 7);
    else if (sel < 85) pos = $urandom_range(0, 4095);
    else               pos = len_eff - 2 + $urandom_range(0, 3);
    c.position = 12'(pos);
    c.category = $urandom_range(0, 1) ? window_cat : 3'($urandom);

    sel = $urandom_range(0, 99);
    if (c.opcode == OP_RANGE_ADD) begin
      if (sel < 80) begin
        c.run_length = 13'($urandom_range(0, 8));
      end else if (sel < 97) begin
        // wide run near the top end: clipped, so still short
        c.run_length = 13'($urandom);
        c.position   = 12'(4095 - $urandom_range(0, 7));
      end else begin
        c.run_length = 13'(POSITIONS);
        c.position   = '0;
      end
    end else if (c.opcode == OP_HIGH_TEST) begin
      if (sel < 60)      c.run_length = 13'($urandom_range(0, 8));
      else if (sel < 80) c.run_length = 13'($urandom);
      else               c.run_length = 13'(len_eff - 1 - int'(c.position) +
                                            $urandom_range(0, 1));
    end else begin
      c.run_length = 13'($urandom);
    end

    sel = $urandom_range(0, 99);
    if (sel < 40)      c.amount = 16'($urandom_range(0, 3));
    else if (sel < 70) c.amount = 16'($urandom_range(0, cap_shadow));
    else if (sel < 85) c.amount = 16'(int'(cap_shadow) - 1 + $urandom_range(0, 2));
    else               c.amount = 16'($urandom);
    return c;
  endfunction

  // Item driver
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && cmd_ready) begin
        expected_results.push_back(apply_table_op(cmd));
        items_accepted++;
      end
      if (!cmd_valid || cmd_ready) begin
        if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cmd <= pending_cmds.pop_front();
          cmd_valid <= 1'b1;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with none expected: value %0d flag %0b",
                                    res.coverage_value, res.high_flag));
        end else begin
          oldest_expected = expected_results.pop_front();
          if (res.coverage_value !== oldest_expected.coverage_value)
            report_mismatch($sformatf("coverage_value %0d, expected %0d",
                                      res.coverage_value, oldest_expected.coverage_value));
          if (res.high_flag !== oldest_expected.high_flag)
            report_mismatch($sformatf("high_flag %0b, expected %0b",
                                      res.high_flag, oldest_expected.high_flag));
        end
      end
      res_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || cmd_valid || expected_results.size() != 0);
    repeat (10) @(negedge clk);
  endtask

  // Writes both limits back to back; block must be idle
  task automatic program_limits(input logic [15:0] cap_val, input logic [15:0] len_data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= REG_MAX_COVERAGE;
    cfg_data  <= cap_val;
    do @(posedge clk);
    while (!cfg_ready);
    cap_shadow = cap_val;
    cfg_index <= REG_LENGTH_IN_USE;
    cfg_data  <= len_data;
    do @(posedge clk);
    while (!cfg_ready);
    length_shadow = len_data[12:0];
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic run_random_phase(input logic [15:0] cap_val, input logic [15:0] len_data,
                                  input int send_pct, input int recv_pct);
    int len_eff;
    program_limits(cap_val, len_data);
    @(negedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    len_eff = active_length();
    window_base = (len_eff > 4) ? $urandom_range(0, len_eff - 4) : 0;
    window_cat  = 3'($urandom);
    repeat (PHASE_ITEMS)
      pending_cmds.push_back(random_table_op());
    wait_drained();
  endtask

  initial begin
    foreach (coverage_model[i])
      coverage_model[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: field extremes, cap edges, bound of the high test, clear
    pending_cmds.push_back(make_cmd(OP_GET,       0,    0, 0,    0));
    pending_cmds.push_back(make_cmd(OP_POINT_ADD, 4095, 7, 0,    65535));
    pending_cmds.push_back(make_cmd(OP_POINT_ADD, 4095, 7, 0,    65534));
    pending_cmds.push_back(make_cmd(OP_RANGE_ADD, 4095, 7, 1,    1));
    pending_cmds.push_back(make_cmd(OP_GET,       4095, 7, 0,    0));
    pending_cmds.push_back(make_cmd(OP_HIGH_TEST, 4095, 7, 0,    0));
    pending_cmds.push_back(make_cmd(OP_RANGE_ADD, 0,    0, 0,    5));
    pending_cmds.push_back(make_cmd(OP_RANGE_ADD, 4000, 3, 8191, 65535));
    pending_cmds.push_back(make_cmd(OP_HIGH_TEST, 4000, 3, 95,   0));
    pending_cmds.push_back(make_cmd(OP_HIGH_TEST, 4001, 3, 95,   0));
    pending_cmds.push_back(make_cmd(OP_HIGH_TEST, 4001, 3, 8191, 0));
    pending_cmds.push_back(make_cmd(OP_SET,       100,  2, 0,    65535));
    pending_cmds.push_back(make_cmd(OP_GET,       100,  2, 0,    0));
    pending_cmds.push_back(make_cmd(OP_SPARE_A,   4095, 7, 8191, 65535));
    pending_cmds.push_back(make_cmd(OP_SPARE_B,   4095, 7, 8191, 65535));
    pending_cmds.push_back(make_cmd(OP_SET,       0,    0, 0,    0));
    pending_cmds.push_back(make_cmd(OP_CLEAR,     0,    0, 0,    0));
    pending_cmds.push_back(make_cmd(OP_GET,       4095, 7, 0,    0));
    pending_cmds.push_back(make_cmd(OP_RANGE_ADD, 0,    0, 1,    1));
    pending_cmds.push_back(make_cmd(OP_GET,       0,    0, 0,    0));
    pending_cmds.push_back(make_cmd(OP_RANGE_ADD, 0,    1, 4096, 1));
    pending_cmds.push_back(make_cmd(OP_GET,       4095, 1, 0,    0));
    wait_drained();

    // Random phases over several limits and idle patterns
    run_random_phase(16'hFFFF, 16'd4096, 0,  0);
    run_random_phase(16'd0,    16'd4096, 67, 0);
    run_random_phase(16'd1,    16'd1,    0,  67);
    run_random_phase(16'd12,   16'd64,   27, 27);
    run_random_phase(16'd300,  16'd0,    0,  0);
    // lowered cap: counters from earlier phases may already sit above it
    run_random_phase(16'd8,    16'd8191, 67, 0);
    run_random_phase(16'($urandom), 16'($urandom), 0, 67);
    run_random_phase(16'hFFFF, 16'd4096, 27, 27);

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Ran %0d items over %0d limit settings and four idle patterns", items_accepted,
             settings_used);
    $display("High tests that hit: %0d, clears: %0d, mismatches: %0d", high_hits,
             clears_seen, error_count);
    if (error_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
